// File: sv/bssw_pkg.sv
// Shared types, constants and helpers for the bank switch sound window mapper.
package bssw_pkg;

    localparam int STORE_BYTES = 131072;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int PAGE_BYTES  = 8192;
    localparam int PAGE_AW     = $clog2(PAGE_BYTES);
    localparam int NUM_PAGES   = 4;

    // cartridge type codes; codes above CART_EXTENDED act as plain
    localparam logic [2:0] CART_PLAIN       = 3'd0;
    localparam logic [2:0] CART_SNATCHER    = 3'd1;
    localparam logic [2:0] CART_SD_SNATCHER = 3'd2;
    localparam logic [2:0] CART_MIRRORED    = 3'd3;
    localparam logic [2:0] CART_EXTENDED    = 3'd4;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_MEM    = 2'd0,
        KIND_SND_RD = 2'd1,
        KIND_SND_WR = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WIN_NONE   = 2'd0,
        WIN_COMPAT = 2'd1,
        WIN_PLUS   = 2'd2
    } win_t;

    // one store access per beat: a read or a write at one address
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } store_req_t;

    // result fields waiting for the store read data
    typedef struct packed {
        kind_t      kind;
        logic       use_mem;
        logic [7:0] rdata;
        logic [7:0] sreg;
        logic [7:0] sdata;
        win_t       mode;
    } stage_t;

    function automatic logic [3:0] bank_mask(input logic [2:0] cart);
        bank_mask = (cart == CART_MIRRORED) ? 4'h7 : 4'hf;
    endfunction

    function automatic win_t window_of(input logic [7:0] mode, input logic [7:0] bank2,
                                       input logic [7:0] bank3);
        if (mode[5] && bank3[7])
            window_of = WIN_PLUS;
        else if (!mode[5] && (bank2[5:0] == 6'h3f))
            window_of = WIN_COMPAT;
        else
            window_of = WIN_NONE;
    endfunction

endpackage

// File: sv/bssw_store.sv
// Image byte store: synchronous single-port memory with a 0xFF clearing sweep after reset.
module bssw_store (
    input  logic                clk,
    input  logic                rst_n,
    input  bssw_pkg::store_req_t req,
    output logic [7:0]          rd_data,
    output logic                clear_busy
);
    import bssw_pkg::*;

    logic [7:0]          store_mem [STORE_BYTES];
    logic [7:0]          rd_data_reg;
    logic [STORE_AW-1:0] clear_addr_reg;
    logic [STORE_AW-1:0] clear_addr_next;
    logic                clear_busy_reg;
    logic                clear_busy_next;

    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        clear_busy_next = clear_busy_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == STORE_AW'(STORE_BYTES - 1))
                clear_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            clear_busy_reg <= 1'b1;
        end
        else
        begin
            clear_addr_reg <= clear_addr_next;
            clear_busy_reg <= clear_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy_reg)
            store_mem[clear_addr_reg] <= 8'hff;
        else if (req.wr_en)
            store_mem[req.addr] <= req.wdata;
        if (req.rd_en)
            rd_data_reg <= store_mem[req.addr];
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clear_busy_reg;

endmodule

// File: sv/bank_switch_sound_window_mapper_core.sv
// Top level of the bank switch sound window mapper: decode, mapper registers, result pipeline.
//
// Input channel (in_valid / in_stall) carries one command per beat: CPU read or write at
// cpu_offset (address minus 0x4000), image byte load at image_offset, or mapper init.
// Output channel (out_valid / out_stall) returns exactly one result beat per command:
// kind, read_data, sound_reg, sound_data and the sound window after the command.
// cfg_write / cfg_data set the cartridge type; write it only while the block is idle.
//
// Throughput is one command per cycle while neither out_stall nor the clearing sweep holds
// the input. A command passes the read stage for the store read, then the output register.
// Mapper registers are updated in the accept cycle, so back-to-back commands see the
// bank and mode writes of the one before; the store is written in that cycle too.
//
// After reset the store is swept to 0xFF at one byte a cycle with in_stall held high;
// the mapper registers come up as for a plain cartridge.
// When out_stall holds a result, one more command is taken into the read stage and
// then in_stall rises until the output beat moves.
module bank_switch_sound_window_mapper_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [14:0] cpu_offset,
    input  logic [7:0] data,
    input  logic [16:0] image_offset,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] read_data,
    output logic [7:0] sound_reg,
    output logic [7:0] sound_data,
    output logic [1:0] sound_mode
);
    import bssw_pkg::*;

    logic [2:0]           cart_reg;
    logic [7:0]           bank_reg  [NUM_PAGES];
    logic [7:0]           bank_next [NUM_PAGES];
    logic [NUM_PAGES-1:0] mapped_reg;
    logic [NUM_PAGES-1:0] mapped_next;
    logic [NUM_PAGES-1:0] ram_reg;
    logic [NUM_PAGES-1:0] ram_next;
    logic [7:0]           mode_reg;
    logic [7:0]           mode_next;
    win_t                 window_reg;
    win_t                 window_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    stage_t               s1_reg;
    stage_t               s1_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    kind_t                kind_reg;
    logic [7:0]           read_data_reg;
    logic [7:0]           sound_reg_reg;
    logic [7:0]           sound_data_reg;
    win_t                 sound_mode_reg;

    store_req_t           store_req;
    logic [7:0]           mem_rdata;
    logic                 clear_busy;

    logic                 accept;
    logic                 s1_adv;
    logic [1:0]           page;
    logic [3:0]           bank_m;
    logic [3:0]           sel_m;
    logic [STORE_AW+3:0]  full_idx;
    logic                 in_win;
    logic                 is_mode_addr;
    logic                 is_bank_sel;
    logic                 upd_win;
    logic                 do_init;

    bssw_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (store_req),
        .rd_data    (mem_rdata),
        .clear_busy (clear_busy)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clear_busy || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;

    assign page         = cpu_offset[14:13];
    assign bank_m       = bank_reg[page][3:0] & bank_mask(cart_reg);
    assign sel_m        = data[3:0] & bank_mask(cart_reg);
    assign full_idx     = {{STORE_AW{1'b0}}, bank_m} << PAGE_AW;
    assign is_mode_addr = &cpu_offset[14:1];
    assign is_bank_sel  = (cpu_offset[12:11] == 2'b10);
    assign in_win       = ((window_reg == WIN_COMPAT) && (cpu_offset[14:11] == 4'hb)) ||
                          ((window_reg == WIN_PLUS)   && (cpu_offset[14:11] == 4'hf));

    always_comb
    begin
        for (int i = 0; i < NUM_PAGES; i++)
            bank_next[i] = bank_reg[i];
        mapped_next     = mapped_reg;
        ram_next        = ram_reg;
        mode_next       = mode_reg;
        upd_win         = 1'b0;
        do_init         = 1'b0;
        store_req.rd_en = 1'b0;
        store_req.wr_en = 1'b0;
        store_req.addr  = full_idx[STORE_AW-1:0] | STORE_AW'(cpu_offset[PAGE_AW-1:0]);
        store_req.wdata = data;
        s1_next.kind    = KIND_NONE;
        s1_next.use_mem = 1'b0;
        s1_next.rdata   = 8'h00;
        s1_next.sreg    = 8'h00;
        s1_next.sdata   = 8'h00;
        if (accept)
        begin
            unique case (cmd_t'(cmd))
                CMD_READ:
                begin
                    if (in_win)
                    begin
                        s1_next.kind = KIND_SND_RD;
                        s1_next.sreg = cpu_offset[7:0];
                    end
                    else
                    begin
                        s1_next.kind = KIND_MEM;
                        if (mapped_reg[page])
                        begin
                            s1_next.use_mem = 1'b1;
                            store_req.rd_en = 1'b1;
                        end
                        else
                            s1_next.rdata = 8'hff;
                    end
                end
                CMD_WRITE:
                begin
                    priority if (is_mode_addr)
                    begin
                        mode_next   = data;
                        ram_next[0] = (data & 8'h11) != 8'h00;
                        ram_next[1] = (data & 8'h12) != 8'h00;
                        ram_next[2] = data[4] || ((data & 8'h24) == 8'h24);
                        ram_next[3] = data[4];
                        upd_win     = 1'b1;
                    end
                    else if (ram_reg[page])
                    begin
                        // drop writes to an unmapped RAM page
                        store_req.wr_en = mapped_reg[page];
                    end
                    else if (is_bank_sel)
                    begin
                        bank_next[page]   = data;
                        mapped_next[page] = (sel_m[3] && (cart_reg != CART_SNATCHER)) ||
                                            (!sel_m[3] && (cart_reg != CART_SD_SNATCHER));
                        upd_win           = 1'b1;
                    end
                    else if (in_win)
                    begin
                        s1_next.kind  = KIND_SND_WR;
                        s1_next.sreg  = cpu_offset[7:0];
                        s1_next.sdata = data;
                    end
                end
                CMD_LOAD:
                begin
                    store_req.addr  = image_offset[STORE_AW-1:0];
                    store_req.wr_en = ({1'b0, image_offset} < 18'(STORE_BYTES));
                end
                CMD_INIT:
                begin
                    do_init = 1'b1;
                    for (int i = 0; i < NUM_PAGES; i++)
                        bank_next[i] = 8'(i);
                    mapped_next = (cart_reg == CART_SD_SNATCHER) ? '0 : '1;
                    ram_next    = '0;
                    mode_next   = (cart_reg == CART_EXTENDED) ? 8'h20 : 8'h00;
                end
            endcase
        end
        if (do_init)
            window_next = WIN_NONE;
        else if (upd_win)
            window_next = window_of(mode_next, bank_next[2], bank_next[3]);
        else
            window_next = window_reg;
        s1_next.mode = window_next;
    end

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_reg      <= CART_PLAIN;
            for (int i = 0; i < NUM_PAGES; i++)
                bank_reg[i] <= 8'(i);
            mapped_reg    <= '1;
            ram_reg       <= '0;
            mode_reg      <= 8'h00;
            window_reg    <= WIN_NONE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                cart_reg <= cfg_data;
            for (int i = 0; i < NUM_PAGES; i++)
                bank_reg[i] <= bank_next[i];
            mapped_reg    <= mapped_next;
            ram_reg       <= ram_next;
            mode_reg      <= mode_next;
            window_reg    <= window_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv)
        begin
            kind_reg       <= s1_reg.kind;
            read_data_reg  <= s1_reg.use_mem ? mem_rdata : s1_reg.rdata;
            sound_reg_reg  <= s1_reg.sreg;
            sound_data_reg <= s1_reg.sdata;
            sound_mode_reg <= s1_reg.mode;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign read_data  = read_data_reg;
    assign sound_reg  = sound_reg_reg;
    assign sound_data = sound_data_reg;
    assign sound_mode = sound_mode_reg;

    // no beat may enter while the clearing sweep owns the store
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !accept)
        else $error("input beat accepted during store clear");

    // a store read only issues for an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.rd_en |-> accept)
        else $error("store read without an accepted beat");

    // plus window needs mode bit 5 and bank 3 bit 7
    assert property (@(posedge clk) disable iff (!rst_n)
        (window_reg == WIN_PLUS) |-> (mode_reg[5] && bank_reg[3][7]))
        else $error("plus window open without its enables");

    // a sound read can only come from an open window
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_SND_RD)) |-> (sound_mode_reg != WIN_NONE))
        else $error("sound read reported with window closed");

    // a held result keeps the read stage from dropping its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("read stage lost a beat under stall");

endmodule
